[hw/rtl/sfd_pkg.sv]
// sfd_pkg: shared types and constants for the stereo feedback delay.
// Holds the sequencer states, the register indexes and the command struct.
// No dependencies.
package sfd_pkg;

  localparam int unsigned DelayRegBits = 23;
  localparam int unsigned GainBits     = 16;
  localparam int unsigned CfgDataBits  = 23;
  localparam int unsigned CfgIdxBits   = 3;

  localparam logic [GainBits-1:0]        GainUnity     = 16'd32768;
  localparam logic signed [GainBits-1:0] FeedbackLimit = 16'sd31130;

  localparam logic [DelayRegBits-1:0] DelayLeftRst  = 23'd3072000;
  localparam logic [DelayRegBits-1:0] DelayRightRst = 23'd4608000;
  localparam logic [GainBits-1:0]     DryGainRst    = 16'd32768;
  localparam logic [GainBits-1:0]     WetGainRst    = 16'd6554;
  localparam logic [GainBits-1:0]     FeedbackRst   = 16'd0;
  localparam logic [GainBits-1:0]     AlphaRst      = 16'd29878;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_DELAY_LEFT  = 3'd0,
    CFG_DELAY_RIGHT = 3'd1,
    CFG_DRY_GAIN    = 3'd2,
    CFG_WET_GAIN    = 3'd3,
    CFG_FEEDBACK    = 3'd4,
    CFG_ALPHA       = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADDR,
    ST_RD_A,
    ST_RD_B,
    ST_INTERP,
    ST_TAP,
    ST_LP_MUL,
    ST_LP_SUM,
    ST_GAIN_MUL,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic load_x;
    logic calc_addr;
    logic rd_first;
    logic rd_second;
    logic interp;
    logic tap;
    logic lp_mul;
    logic lp_sum;
    logic gain_mul;
    logic commit;
  } cmd_t;

endpackage

[hw/rtl/sfd_channel.sv]
// sfd_channel: one delay line with its tap interpolator, lowpass and mixer.
// Depends on sfd_pkg (cmd_t, DelayRegBits).
module sfd_channel #(
  parameter int unsigned LINE_DEPTH          = 32768,
  parameter int unsigned SAMPLE_BITS         = 24,
  parameter int unsigned DELAY_FRACTION_BITS = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  sfd_pkg::cmd_t                         cmd_i,
  input  logic signed [SAMPLE_BITS-1:0]         x_i,
  input  logic [sfd_pkg::DelayRegBits-1:0]      delay_i,
  input  logic [$clog2(LINE_DEPTH)-1:0]         widx_i,
  input  logic                                  wrapped_i,
  input  logic signed [16:0]                    wet_i,
  input  logic signed [15:0]                    fb_i,
  input  logic [15:0]                           alpha_i,
  input  logic signed [SAMPLE_BITS+16:0]        xd_i,
  output logic signed [SAMPLE_BITS-1:0]         out_o
);
  import sfd_pkg::*;

  localparam int unsigned AW  = $clog2(LINE_DEPTH);
  localparam int unsigned S   = SAMPLE_BITS;
  localparam int unsigned F   = DELAY_FRACTION_BITS;
  localparam int unsigned FW  = (F == 0) ? 1 : F;
  localparam int unsigned PW  = AW + F;
  localparam int unsigned CW  = ((PW > DelayRegBits) ? PW : DelayRegBits) + 1;
  localparam int unsigned PRW = S + FW + 2;
  localparam int unsigned SW  = S + 19;

  logic [S-1:0] mem [LINE_DEPTH];

  logic [AW-1:0]          i_q, j, raddr;
  logic [FW-1:0]          fr_q, fr_d;
  logic [S-1:0]           rd_q;
  logic                   rvld_q;
  logic signed [S-1:0]    rd_eff, a_q, tap_q, lp_q, out_q;
  logic signed [PRW-1:0]  prod_q;
  logic signed [S+17:0]   m1_q, m2_q;
  logic signed [S+15:0]   fbp_q;
  logic signed [S+17:0]   tw_q;
  logic [CW-1:0]          dmin, dmax, dext, dcl, here, span, p;
  logic [16:0]            oma;
  logic signed [SW-1:0]   wsum, osum, lpsum, tapsum;

  function automatic logic signed [S-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi, lo;
    hi = SW'((64'sd1 <<< (S - 1)) - 64'sd1);
    lo = -hi - SW'(1);
    if (v > hi) begin
      return hi[S-1:0];
    end else if (v < lo) begin
      return lo[S-1:0];
    end
    return v[S-1:0];
  endfunction

  // tap position behind the write index, with the delay clamped
  always_comb begin
    dmin = CW'(1) << F;
    dmax = CW'(LINE_DEPTH - 2) << F;
    dext = CW'(delay_i);
    dcl  = (dext < dmin) ? dmin : ((dext > dmax) ? dmax : dext);
    here = CW'(widx_i) << F;
    span = CW'(LINE_DEPTH) << F;
    p    = (here >= dcl) ? (here - dcl) : (here + span - dcl);
    fr_d = (F == 0) ? '0 : p[FW-1:0];
  end

  assign j      = (i_q == AW'(LINE_DEPTH - 1)) ? '0 : i_q + AW'(1);
  assign raddr  = cmd_i.rd_second ? j : i_q;
  // entries not yet written since reset read as zero
  assign rd_eff = rvld_q ? $signed(rd_q) : '0;
  assign oma    = 17'h10000 - {1'b0, alpha_i};

  assign tapsum = SW'(a_q) + SW'(prod_q >>> F);
  assign lpsum  = (SW'(m1_q) + SW'(m2_q)) >>> 16;
  assign wsum   = SW'(x_i) + SW'(fbp_q >>> 15);
  assign osum   = (SW'(xd_i) + SW'(tw_q)) >>> 15;

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_addr) begin
      i_q  <= p[F +: AW];
      fr_q <= fr_d;
    end
    if (cmd_i.rd_first || cmd_i.rd_second) begin
      rd_q   <= mem[raddr];
      rvld_q <= wrapped_i || (raddr < widx_i);
    end
    if (cmd_i.rd_second) begin
      a_q <= rd_eff;
    end
    if (cmd_i.interp) begin
      prod_q <= PRW'((SW'(rd_eff) - SW'(a_q)) * $signed({1'b0, fr_q}));
    end
    if (cmd_i.tap) begin
      tap_q <= tapsum[S-1:0];
    end
    if (cmd_i.lp_mul) begin
      m1_q <= tap_q * $signed({1'b0, oma});
      m2_q <= (S+18)'(lp_q) * $signed({1'b0, alpha_i});
    end
    if (cmd_i.gain_mul) begin
      fbp_q <= fb_i * lp_q;
      tw_q  <= (S+18)'(tap_q) * wet_i;
    end
    if (cmd_i.commit) begin
      mem[widx_i] <= sat(wsum);
      out_q       <= sat(osum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_q <= '0;
    end else if (cmd_i.lp_sum) begin
      lp_q <= lpsum[S-1:0];
    end
  end

  assign out_o = out_q;

endmodule

[hw/rtl/sfd_datapath.sv]
// sfd_datapath: shared write index, input sample, gain clamps and both channels.
// Depends on sfd_pkg and sfd_channel.
module sfd_datapath #(
  parameter int unsigned LINE_DEPTH          = 32768,
  parameter int unsigned SAMPLE_BITS         = 24,
  parameter int unsigned DELAY_FRACTION_BITS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  sfd_pkg::cmd_t                    cmd_i,
  input  logic signed [SAMPLE_BITS-1:0]    sample_i,
  input  logic [sfd_pkg::DelayRegBits-1:0] delay_left_i,
  input  logic [sfd_pkg::DelayRegBits-1:0] delay_right_i,
  input  logic [15:0]                      dry_i,
  input  logic [15:0]                      wet_i,
  input  logic signed [15:0]               fb_i,
  input  logic [15:0]                      alpha_i,
  output logic signed [SAMPLE_BITS-1:0]    left_o,
  output logic signed [SAMPLE_BITS-1:0]    right_o
);
  import sfd_pkg::*;

  localparam int unsigned AW = $clog2(LINE_DEPTH);
  localparam int unsigned S  = SAMPLE_BITS;

  logic [AW-1:0]        widx_q;
  logic                 wrapped_q;
  logic signed [S-1:0]  x_q;
  logic signed [S+16:0] xd_q;
  logic [15:0]          dry_c, wet_c;
  logic signed [15:0]   fb_c;

  assign dry_c = (dry_i > GainUnity) ? GainUnity : dry_i;
  assign wet_c = (wet_i > GainUnity) ? GainUnity : wet_i;
  assign fb_c  = (fb_i > FeedbackLimit) ? FeedbackLimit :
                 ((fb_i < -FeedbackLimit) ? -FeedbackLimit : fb_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_x) begin
      x_q <= sample_i;
    end
    if (cmd_i.gain_mul) begin
      xd_q <= x_q * $signed({1'b0, dry_c});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q    <= '0;
      wrapped_q <= 1'b0;
    end else if (cmd_i.commit) begin
      if (widx_q == AW'(LINE_DEPTH - 1)) begin
        widx_q    <= '0;
        wrapped_q <= 1'b1;
      end else begin
        widx_q <= widx_q + AW'(1);
      end
    end
  end

  sfd_channel #(
    .LINE_DEPTH(LINE_DEPTH), .SAMPLE_BITS(SAMPLE_BITS),
    .DELAY_FRACTION_BITS(DELAY_FRACTION_BITS)
  ) u_left (
    .clk_i, .rst_ni, .cmd_i, .x_i(x_q), .delay_i(delay_left_i), .widx_i(widx_q),
    .wrapped_i(wrapped_q), .wet_i($signed({1'b0, wet_c})), .fb_i(fb_c),
    .alpha_i, .xd_i(xd_q), .out_o(left_o)
  );

  sfd_channel #(
    .LINE_DEPTH(LINE_DEPTH), .SAMPLE_BITS(SAMPLE_BITS),
    .DELAY_FRACTION_BITS(DELAY_FRACTION_BITS)
  ) u_right (
    .clk_i, .rst_ni, .cmd_i, .x_i(x_q), .delay_i(delay_right_i), .widx_i(widx_q),
    .wrapped_i(wrapped_q), .wet_i($signed({1'b0, wet_c})), .fb_i(fb_c),
    .alpha_i, .xd_i(xd_q), .out_o(right_o)
  );

endmodule

[hw/rtl/sfd_ctrl.sv]
// sfd_ctrl: sequencer for one sample, plus the input and output handshakes.
// Depends on sfd_pkg (state_e, cmd_t).
module sfd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output sfd_pkg::cmd_t cmd_o
);
  import sfd_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_ADDR;
      ST_ADDR:     state_d = ST_RD_A;
      ST_RD_A:     state_d = ST_RD_B;
      ST_RD_B:     state_d = ST_INTERP;
      ST_INTERP:   state_d = ST_TAP;
      ST_TAP:      state_d = ST_LP_MUL;
      ST_LP_MUL:   state_d = ST_LP_SUM;
      ST_LP_SUM:   state_d = ST_GAIN_MUL;
      ST_GAIN_MUL: state_d = ST_WRITE;
      ST_WRITE:    if (slot_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.load_x    = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.calc_addr = (state_q == ST_ADDR);
    cmd_o.rd_first  = (state_q == ST_RD_A);
    cmd_o.rd_second = (state_q == ST_RD_B);
    cmd_o.interp    = (state_q == ST_INTERP);
    cmd_o.tap       = (state_q == ST_TAP);
    cmd_o.lp_mul    = (state_q == ST_LP_MUL);
    cmd_o.lp_sum    = (state_q == ST_LP_SUM);
    cmd_o.gain_mul  = (state_q == ST_GAIN_MUL);
    cmd_o.commit    = (state_q == ST_WRITE) && slot_free;
    in_ready_o      = (state_q == ST_IDLE);
    out_valid_o     = out_valid_q;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[hw/rtl/stereo_feedback_delay.sv]
// stereo_feedback_delay: mono in, stereo out fractional feedback delay.
// One sample at a time: the sequencer takes no input until it has walked the address
// step, two reads of each single-port line memory, the interpolate, lowpass and gain
// multiply steps, then write; the write waits while the output stalls.
// Reset: async active low; registers to defaults, index and lowpass to zero. The lines
// need no clearing pass: entries not yet written since reset read as zero.
module stereo_feedback_delay #(
  parameter int unsigned LINE_DEPTH          = 32768,
  parameter int unsigned SAMPLE_BITS         = 24,
  parameter int unsigned DELAY_FRACTION_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]     sample_in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]     out_left_o,
  output logic signed [SAMPLE_BITS-1:0]     out_right_o,
  input  logic                              cfg_we_i,
  input  logic [sfd_pkg::CfgIdxBits-1:0]    cfg_idx_i,
  input  logic [sfd_pkg::CfgDataBits-1:0]   cfg_wdata_i
);
  import sfd_pkg::*;

  // configuration registers, raw; clamping happens in the datapath
  logic [DelayRegBits-1:0] delay_left_q, delay_right_q;
  logic [GainBits-1:0]     dry_q, wet_q, fb_q, alpha_q;
  cmd_t                    cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_left_q  <= DelayLeftRst;
      delay_right_q <= DelayRightRst;
      dry_q         <= DryGainRst;
      wet_q         <= WetGainRst;
      fb_q          <= FeedbackRst;
      alpha_q       <= AlphaRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DELAY_LEFT:  delay_left_q  <= cfg_wdata_i[DelayRegBits-1:0];
        CFG_DELAY_RIGHT: delay_right_q <= cfg_wdata_i[DelayRegBits-1:0];
        CFG_DRY_GAIN:    dry_q         <= cfg_wdata_i[GainBits-1:0];
        CFG_WET_GAIN:    wet_q         <= cfg_wdata_i[GainBits-1:0];
        CFG_FEEDBACK:    fb_q          <= cfg_wdata_i[GainBits-1:0];
        CFG_ALPHA:       alpha_q       <= cfg_wdata_i[GainBits-1:0];
        default:         ; // unknown index: ignored
      endcase
    end
  end

  // sequencer: one sample in flight, result parked in the output register
  sfd_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd)
  );

  // datapath: two line memories, interpolation, lowpass, mixing
  sfd_datapath #(
    .LINE_DEPTH(LINE_DEPTH), .SAMPLE_BITS(SAMPLE_BITS),
    .DELAY_FRACTION_BITS(DELAY_FRACTION_BITS)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sample_i(sample_in_i),
    .delay_left_i(delay_left_q), .delay_right_i(delay_right_q),
    .dry_i(dry_q), .wet_i(wet_q), .fb_i($signed(fb_q)), .alpha_i(alpha_q),
    .left_o(out_left_o), .right_o(out_right_o)
  );

endmodule

[hw/rtl/sfd_checker.sv]
// sfd_checker: port-level checks for stereo_feedback_delay, bound to the top.
// Depends on nothing but the top level's ports.
module sfd_checker #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [SAMPLE_BITS-1:0] out_left_o,
  input logic [SAMPLE_BITS-1:0] out_right_o
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_left_o) &&
    $stable(out_right_o))
    else $error("output changed while stalled");

  // one sample in flight: no transfer right after a transfer
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  // a result cannot appear in the cycle after an input transfer
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result too early");

  // reset keeps the output channel quiet
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output valid in reset");

endmodule

bind stereo_feedback_delay sfd_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_sfd_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
  .out_left_o(out_left_o), .out_right_o(out_right_o)
);

[test/stereo_feedback_delay_tb.sv]
// stereo_feedback_delay_tb: self-checking bench for the stereo feedback delay.
// Drives mono samples, predicts both taps, lowpass and outputs in-house, checks each transfer.
// Depends on sfd_pkg and stereo_feedback_delay.
module stereo_feedback_delay_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sfd_pkg::*;

  localparam int Depth    = 32768;
  localparam int FracBits = 8;
  localparam int SampMax  = 8388607;
  localparam int SampMin  = -8388608;
  localparam int FbLim    = 31130;
  localparam longint CycleLimit = 4000000;
  localparam logic [CfgIdxBits-1:0] CfgIdxUnused = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [23:0] sample_in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [23:0] out_left_o, out_right_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx_i = '0;
  logic [CfgDataBits-1:0] cfg_wdata_i = '0;

  stereo_feedback_delay dut (.*);

  always #10 clk_i = ~clk_i;

  // predictor state; lines, write position and registers kept at the block's widths
  logic signed [23:0] left_mem [Depth];
  logic signed [23:0] right_mem [Depth];
  logic [14:0] wr_pos;
  longint lp_left, lp_right;
  logic [22:0] dly_left, dly_right;
  logic [15:0] dry_reg, wet_reg, alpha_reg;
  logic signed [15:0] fb_reg;

  typedef struct {
    logic signed [23:0] left;
    logic signed [23:0] right;
  } stereo_t;
  stereo_t pending_outputs[$];

  int errors = 0;
  int mismatches = 0;
  int checked = 0;
  int sent = 0;
  longint cycles = 0;
  bit hold_off = 1'b0;      // long receiver stall requested
  bit rx_random = 1'b1;     // random receiver stalls enabled
  int tx_gap_max = 3;

  // 24-bit saturation; for the floor shift, >>> on a signed longint floors already
  function automatic longint sat24(longint v);
    if (v > SampMax) return SampMax;
    if (v < SampMin) return SampMin;
    return v;
  endfunction

  function automatic longint tap_read(bit right_side, logic [22:0] dly);
    longint d, p, here, span, i, j, fr, a, b;
    d = dly;
    if (d < (1 << FracBits)) d = 1 << FracBits;
    if (d > ((Depth - 2) << FracBits)) d = (Depth - 2) << FracBits;
    here = longint'(wr_pos) << FracBits;
    span = longint'(Depth) << FracBits;
    p = (here >= d) ? here - d : here + span - d;
    i = (p >> FracBits) % Depth;
    j = (i + 1) % Depth;
    fr = p & ((1 << FracBits) - 1);
    a = right_side ? right_mem[i] : left_mem[i];
    b = right_side ? right_mem[j] : left_mem[j];
    return a + (((b - a) * fr) >>> FracBits);
  endfunction

  function automatic void echo_predict(logic signed [23:0] x_in);
    longint x, dry, wet, fb, al, ta, tb;
    stereo_t r;
    x = x_in;
    dry = (dry_reg > GainUnity) ? 32768 : dry_reg;
    wet = (wet_reg > GainUnity) ? 32768 : wet_reg;
    fb = fb_reg;
    if (fb > FbLim) fb = FbLim;
    if (fb < -FbLim) fb = -FbLim;
    al = alpha_reg;
    ta = tap_read(1'b0, dly_left);
    tb = tap_read(1'b1, dly_right);
    lp_left  = ((65536 - al) * ta + al * lp_left) >>> 16;
    lp_right = ((65536 - al) * tb + al * lp_right) >>> 16;
    left_mem[wr_pos]  = 24'(sat24(x + ((fb * lp_left) >>> 15)));
    right_mem[wr_pos] = 24'(sat24(x + ((fb * lp_right) >>> 15)));
    wr_pos = wr_pos + 1'b1;
    r.left  = 24'(sat24((x * dry + ta * wet) >>> 15));
    r.right = 24'(sat24((x * dry + tb * wet) >>> 15));
    pending_outputs.push_back(r);
  endfunction

  function automatic void model_reset();
    foreach (left_mem[k]) begin
      left_mem[k] = '0;
      right_mem[k] = '0;
    end
    wr_pos = '0;
    lp_left = 0;
    lp_right = 0;
    dly_left = DelayLeftRst;
    dly_right = DelayRightRst;
    dry_reg = DryGainRst;
    wet_reg = WetGainRst;
    fb_reg = FeedbackRst;
    alpha_reg = AlphaRst;
  endfunction

  // cycle counter doubles as the watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("stereo_feedback_delay_tb NOT OK");
      $finish;
    end
  end

  // receiver: random stalls, mostly short, some long; hold_off forces a long stall
  initial begin : receiver
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_off || (rx_random && $urandom_range(0, 3) == 0)) begin
        out_ready_i <= 1'b0;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
        repeat (n - 1) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // checker: compares each output transfer with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_outputs.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected output %0d/%0d", out_left_o, out_right_o);
      end else begin
        stereo_t e;
        e = pending_outputs.pop_front();
        checked++;
        if (e.left !== out_left_o || e.right !== out_right_o) begin
          errors++;
          if (mismatches++ < 10)
            $display("output %0d: expected L=%0d R=%0d got L=%0d R=%0d",
                     checked, e.left, e.right, out_left_o, out_right_o);
        end
      end
    end
  end

  // valid drops between items
  task automatic send_sample(logic signed [23:0] x);
    int gap;
    gap = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 40) : $urandom_range(0, tx_gap_max);
    repeat (gap + 1) @(posedge clk_i);
    in_valid_i <= 1'b1;
    sample_in_i <= x;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    echo_predict(x);
    sent++;
    in_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // only called after drain(), so the block is idle
  task automatic write_reg(cfg_idx_e idx, logic [CfgDataBits-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_DELAY_LEFT:  dly_left = val;
      CFG_DELAY_RIGHT: dly_right = val;
      CFG_DRY_GAIN:    dry_reg = val[15:0];
      CFG_WET_GAIN:    wet_reg = val[15:0];
      CFG_FEEDBACK:    fb_reg = val[15:0];
      CFG_ALPHA:       alpha_reg = val[15:0];
      default: ;
    endcase
  endtask

  task automatic unknown_reg_write();
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgIdxUnused;
    cfg_wdata_i <= '1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [23:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return SampMax;
      1: return SampMin;
      2: return 24'($signed($urandom_range(0, 255)) - 128);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic set_mix(int dl, int dr, int dry, int wet, int fb, int al);
    drain();
    write_reg(CFG_DELAY_LEFT, 23'(dl));
    write_reg(CFG_DELAY_RIGHT, 23'(dr));
    write_reg(CFG_DRY_GAIN, 23'(dry & 16'hffff));
    write_reg(CFG_WET_GAIN, 23'(wet & 16'hffff));
    write_reg(CFG_FEEDBACK, 23'(fb & 16'hffff));
    write_reg(CFG_ALPHA, 23'(al & 16'hffff));
  endtask

  // reset values, field extremes, short delays with fraction
  task automatic test_directed();
    logic signed [23:0] pat [12] = '{24'sd8388607, -24'sd8388608, 24'sd0, -24'sd1, 24'sd1,
                                     24'sh555555, 24'shaaaaaa, 24'sd8388607, 24'sd8388607,
                                     -24'sd8388608, 24'sd12345, -24'sd4321};
    foreach (pat[k]) send_sample(pat[k]);
    // short taps, full wet, max positive feedback, dry above unity clamps
    set_mix(256 + 128, 3 * 256 + 1, 65535, 40000, FbLim, 0);
    foreach (pat[k]) send_sample(pat[k]);
  endtask

  // clamp corners: delay below minimum and above maximum, feedback beyond limit
  task automatic test_clamps();
    set_mix(0, 23'h7fffff, 0, 32768, -32768, 65535);
    repeat (10) send_sample(rand_sample());
    set_mix(100, (Depth - 2) << FracBits, 32768, 32768, 32767, 1);
    repeat (10) send_sample(rand_sample());
    unknown_reg_write();
    repeat (5) send_sample(rand_sample());
  endtask

  // random settings, short taps so feedback recirculates often
  task automatic test_random();
    repeat (12) begin
      set_mix($urandom_range(0, 40 * 256), $urandom_range(0, 40 * 256),
              $urandom_range(0, 40000), $urandom_range(0, 40000),
              $urandom_range(0, 65535), $urandom_range(0, 65535));
      repeat (50) send_sample(rand_sample());
    end
  endtask

  // receiver stalls long while the sender keeps offering; sender waits out the drain, then sends with no stalls
  task automatic test_backpressure();
    int n;
    set_mix(5 * 256 + 77, 2 * 256, 32768, 20000, -20000, 40000);
    tx_gap_max = 0;
    hold_off = 1'b1;
    fork
      begin
        n = 0;
        while (n < 400) begin
          @(posedge clk_i);
          n++;
        end
        hold_off = 1'b0;
      end
      repeat (40) send_sample(rand_sample());
    join
    drain();
    rx_random = 1'b0;
    repeat (40) send_sample(rand_sample());
    rx_random = 1'b1;
    tx_gap_max = 3;
  endtask

  initial begin
    model_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_clamps();
    test_random();
    test_backpressure();
    drain();
    $display("%0d samples sent, %0d stereo outputs checked, %0d mismatches", sent, checked, errors);
    $display("covered reset settings, delay and gain clamps, feedback extremes, long stalls");
    if (errors == 0 && pending_outputs.size() == 0) begin
      $display("stereo_feedback_delay_tb OK");
    end else begin
      $display("stereo_feedback_delay_tb NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/sfd_pkg.sv
hw/rtl/sfd_channel.sv
hw/rtl/sfd_datapath.sv
hw/rtl/sfd_ctrl.sv
hw/rtl/stereo_feedback_delay.sv
hw/rtl/sfd_checker.sv
test/stereo_feedback_delay_tb.sv
